// ----- hw/rtl/dws_pkg.sv -----
// ----------------------------------------------------------------------------
// dws_pkg
// Shared types, command and error codes, and slot arithmetic for the
// double-ended queue with key search.
// ----------------------------------------------------------------------------
package dws_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * DEPTH);

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_SEARCH     = 3'd4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  symbol;
        logic [15:0] occurrence_count;
    } in_t;

    typedef struct packed {
        logic [7:0]  front_symbol;
        logic [15:0] front_count;
        logic [7:0]  back_symbol;
        logic [15:0] back_count;
        logic        is_empty;
        logic        found;
        logic [5:0]  found_position;
        logic [15:0] found_count;
        logic [1:0]  error;
    } out_t;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [15:0] count;
    } entry_t;

    // slot of the entry that sits pos places behind the front
    function automatic logic [IDX_W-1:0] slot_at(logic [IDX_W-1:0] front,
                                                 logic [FILL_W-1:0] pos);
        logic [SUM_W-1:0] s;
        s = SUM_W'(front) + SUM_W'(pos);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return IDX_W'(s);
    endfunction

endpackage

// ----- hw/rtl/dws_store.sv -----
// ----------------------------------------------------------------------------
// dws_store
// Entry memory: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module dws_store (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [dws_pkg::IDX_W-1:0] wr_addr,
    input  dws_pkg::entry_t           wr_data,
    input  logic [dws_pkg::IDX_W-1:0] rd_addr_a,
    input  logic [dws_pkg::IDX_W-1:0] rd_addr_b,
    output dws_pkg::entry_t           rd_data_a,
    output dws_pkg::entry_t           rd_data_b
);

    dws_pkg::entry_t mem [dws_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- hw/rtl/deque_with_key_search.sv -----
// ----------------------------------------------------------------------------
// deque_with_key_search
// Bounded double-ended queue of symbol/count entries with search by symbol.
// ----------------------------------------------------------------------------
// Input channel s_*: one command per transfer (push front, push back, pop
// front, pop back, search). Result channel m_*: exactly one result per
// command, giving the front and back entries after the command, an empty
// flag, the search outcome and an error code (pop on empty, push on full;
// the queue is left unchanged in both cases).
// A push or pop goes through these steps in order: the transfer edge updates
// the pointers and writes the entry, then the memory is read, front and back
// are captured and the output register is loaded. s_ready comes back when
// the output register is loaded. A search adds a walk over the held entries,
// one memory read and one compare per cycle, stopping at the first match.
// s_ready is high only while no command is in work. The output register lets
// the next command be taken while a result waits; a command that finishes
// while m_valid is still stalled holds until the output is free. Reset
// (aresetn low, synchronous) empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module deque_with_key_search (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dws_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dws_pkg::out_t  m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LATCH,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [dws_pkg::IDX_W-1:0]  front_reg, front_next;
    logic [dws_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [dws_pkg::FILL_W-1:0] pos_reg, pos_next;
    logic [dws_pkg::FILL_W-1:0] chk_pos_reg, chk_pos_next;
    logic                       chk_vld_reg, chk_vld_next;
    logic                       search_reg, search_next;
    logic [7:0]                 key_reg, key_next;
    dws_pkg::out_t              res_reg, res_next;
    dws_pkg::out_t              out_reg, out_next;
    logic                       m_valid_reg, m_valid_next;

    logic                       wr_en;
    logic [dws_pkg::IDX_W-1:0]  wr_addr;
    dws_pkg::entry_t            wr_data;
    logic [dws_pkg::IDX_W-1:0]  rd_addr_a;
    logic [dws_pkg::IDX_W-1:0]  rd_addr_b;
    dws_pkg::entry_t            rd_data_a;
    dws_pkg::entry_t            rd_data_b;
    logic                       is_full;
    logic                       issue_ok;

    dws_store u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign is_full  = (fill_reg == dws_pkg::FILL_W'(dws_pkg::DEPTH));
    assign issue_ok = (pos_reg < fill_reg);

    assign wr_data.symbol = s_data.symbol;
    assign wr_data.count  = s_data.occurrence_count;

    assign rd_addr_a = (state_reg == ST_SCAN) ? dws_pkg::slot_at(front_reg, pos_reg)
                                              : front_reg;
    assign rd_addr_b = (fill_reg == '0) ? '0
                     : dws_pkg::slot_at(front_reg, fill_reg - dws_pkg::FILL_W'(1));

    always_comb begin
        state_next   = state_reg;
        front_next   = front_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        chk_pos_next = chk_pos_reg;
        chk_vld_next = chk_vld_reg;
        search_next  = search_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        wr_addr      = front_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next    = '0;
                    key_next    = s_data.symbol;
                    search_next = (s_data.command == dws_pkg::CMD_SEARCH);
                    state_next  = ST_FETCH;
                    unique case (s_data.command)
                        dws_pkg::CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                res_next.error = dws_pkg::ERR_FULL;
                            end else begin
                                front_next = (front_reg == '0)
                                           ? dws_pkg::IDX_W'(dws_pkg::DEPTH - 1)
                                           : front_reg - dws_pkg::IDX_W'(1);
                                wr_en      = 1'b1;
                                wr_addr    = front_next;
                                fill_next  = fill_reg + dws_pkg::FILL_W'(1);
                            end
                        end
                        dws_pkg::CMD_PUSH_BACK: begin
                            if (is_full) begin
                                res_next.error = dws_pkg::ERR_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = dws_pkg::slot_at(front_reg, fill_reg);
                                fill_next = fill_reg + dws_pkg::FILL_W'(1);
                            end
                        end
                        dws_pkg::CMD_POP_FRONT: begin
                            if (fill_reg == '0) begin
                                res_next.error = dws_pkg::ERR_EMPTY;
                            end else begin
                                front_next = dws_pkg::slot_at(front_reg,
                                                              dws_pkg::FILL_W'(1));
                                fill_next  = fill_reg - dws_pkg::FILL_W'(1);
                            end
                        end
                        dws_pkg::CMD_POP_BACK: begin
                            if (fill_reg == '0) begin
                                res_next.error = dws_pkg::ERR_EMPTY;
                            end else begin
                                fill_next = fill_reg - dws_pkg::FILL_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // memory addressed with the updated front and back slots
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                if (fill_reg == '0) begin
                    res_next.front_symbol = '0;
                    res_next.front_count  = '0;
                    res_next.back_symbol  = '0;
                    res_next.back_count   = '0;
                    res_next.is_empty     = 1'b1;
                end else begin
                    res_next.front_symbol = rd_data_a.symbol;
                    res_next.front_count  = rd_data_a.count;
                    res_next.back_symbol  = rd_data_b.symbol;
                    res_next.back_count   = rd_data_b.count;
                    res_next.is_empty     = 1'b0;
                end
                pos_next     = '0;
                chk_vld_next = 1'b0;
                state_next   = search_reg ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                // issue one read and check the previous one each cycle
                if (chk_vld_reg && (rd_data_a.symbol == key_reg)) begin
                    res_next.found          = 1'b1;
                    res_next.found_position = 6'(chk_pos_reg);
                    res_next.found_count    = rd_data_a.count;
                    chk_vld_next            = 1'b0;
                    state_next              = ST_FINISH;
                end else if (issue_ok) begin
                    chk_vld_next = 1'b1;
                    chk_pos_next = pos_reg;
                    pos_next     = pos_reg + dws_pkg::FILL_W'(1);
                end else begin
                    chk_vld_next = 1'b0;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            fill_reg    <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            fill_reg    <= fill_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg     <= pos_next;
        chk_pos_reg <= chk_pos_next;
        search_reg  <= search_next;
        key_reg     <= key_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= dws_pkg::FILL_W'(dws_pkg::DEPTH))
        else $error("fill level above depth");

    a_full_push_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && is_full &&
         (s_data.command == dws_pkg::CMD_PUSH_FRONT ||
          s_data.command == dws_pkg::CMD_PUSH_BACK))
        |=> $stable(fill_reg) && $stable(front_reg))
        else $error("push on full changed the queue");

    a_scan_keeps_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> $stable(fill_reg) && $stable(front_reg))
        else $error("queue pointers moved during search");

    a_check_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && chk_vld_reg) |-> (chk_pos_reg < fill_reg))
        else $error("search checked a position past the back");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> (res_reg.is_empty == (fill_reg == '0)))
        else $error("empty flag disagrees with fill level");

endmodule
